// ----- design/stereo_correlation_meter_unit_defines.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the stereo correlation meter
// Shared concurrent assertion forms with a synchronous active-low reset.
// ---------------------------------------------------------------------------
`ifndef STEREO_CORRELATION_METER_UNIT_DEFINES_SVH
`define STEREO_CORRELATION_METER_UNIT_DEFINES_SVH

// The property must hold at every clock edge outside reset.
`define SCM_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// The condition must never be seen at a clock edge outside reset.
`define SCM_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

// ----- design/scm_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Stereo correlation meter package
// Fixed field widths, constants and shared types.
// ---------------------------------------------------------------------------
package scm_pkg;

    // Field widths fixed by the sample and result formats.
    localparam int SAMPLE_W = 16;
    localparam int CORR_W   = 16;
    localparam int FLOOR_W  = 31;
    localparam int WIDE_W   = 64;
    localparam int ROOT_W   = 16;

    // Variance floor after reset, in units of 2^-30.
    localparam logic [FLOOR_W-1:0] FLOOR_RESET = 31'd107374;

    // Saturation limits of the Q1.15 result.
    localparam logic signed [CORR_W-1:0] CORR_MAX = 16'sh7FFF;
    localparam logic signed [CORR_W-1:0] CORR_MIN = 16'sh8000;

    // Status of the snapshot queue between front and back.
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

// ----- design/scm_if.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Stereo correlation meter channels
// Valid/ready channels for the sample input and the result output.
// ---------------------------------------------------------------------------
interface scm_in_if;
    import scm_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] left_sample;
    logic signed [SAMPLE_W-1:0] right_sample;

    modport source (output valid, output left_sample, output right_sample, input ready);
    modport sink   (input valid, input left_sample, input right_sample, output ready);
endinterface

interface scm_out_if;
    import scm_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [CORR_W-1:0] correlation;
    logic                     level_too_low;

    modport source (output valid, output correlation, output level_too_low, input ready);
    modport sink   (input valid, input correlation, input level_too_low, output ready);
endinterface

// ----- design/scm_queue.sv -----
`timescale 1ns / 1ps
`include "stereo_correlation_meter_unit_defines.svh"
// ---------------------------------------------------------------------------
// Snapshot queue
// Two-entry queue that carries running-sum snapshots from front to back.
// ---------------------------------------------------------------------------
module scm_queue #(
    parameter int DW = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  logic [DW-1:0]       i_push_data,
    input  logic                i_pop,
    output logic [DW-1:0]       o_pop_data,
    output scm_pkg::t_q_status  o_qstat
);
    import scm_pkg::*;

    logic [DW-1:0] r_mem [2];
    logic          r_wp;
    logic          r_rp;
    logic [1:0]    r_cnt;

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

    // Storage needs no reset.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_push_data;
        end
    end

    assign o_pop_data    = r_mem[r_rp];
    assign o_qstat.full  = (r_cnt == 2'd2);
    assign o_qstat.empty = (r_cnt == 2'd0);

    `SCM_NEVER(a_push_full, i_clk, i_rst_n, i_push && r_cnt == 2'd2 && !i_pop, "push into full queue")
    `SCM_NEVER(a_pop_empty, i_clk, i_rst_n, i_pop && r_cnt == 2'd0, "pop from empty queue")
    `SCM_NEVER(a_cnt_range, i_clk, i_rst_n, r_cnt == 2'd3, "queue level out of range")

endmodule

// ----- design/scm_front.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Correlation meter front end
// Takes sample pairs, swaps them through the window ring and keeps the
// running sums; each updated set of sums is pushed into the snapshot queue.
// ---------------------------------------------------------------------------
module scm_front #(
    parameter int  WINDOW = 1024,
    localparam int CL     = $clog2(WINDOW),
    localparam int AW     = (CL < 1) ? 1 : CL,
    localparam int SLW    = 16 + CL,
    localparam int QW     = 31 + CL,
    localparam int XW     = 32 + CL,
    localparam int DW     = 2 * SLW + 2 * QW + XW
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    scm_in_if.sink             i_sample,
    input  scm_pkg::t_q_status i_qstat,
    output logic               o_push,
    output logic [DW-1:0]      o_push_data
);
    import scm_pkg::*;

    typedef enum logic [1:0] {
        F_IDLE,
        F_OLD,
        F_UPD
    } t_fstate;

    t_fstate r_state;

    // Window ring and its read register.
    logic [2*SAMPLE_W-1:0] r_mem [WINDOW];
    logic [2*SAMPLE_W-1:0] r_rd;
    logic [AW-1:0]         r_widx;
    logic                  r_full;

    // Current and retiring pair with their products.
    logic signed [SAMPLE_W-1:0]   r_l, r_r, r_ol, r_or;
    logic [2*SAMPLE_W-1:0]        r_pll, r_prr, r_poll, r_porr;
    logic signed [2*SAMPLE_W-1:0] r_plr, r_polr;

    // Running sums.
    logic signed [SLW-1:0] r_sl, r_sr;
    logic [QW-1:0]         r_sll, r_srr;
    logic signed [XW-1:0]  r_slr;
    logic signed [SLW-1:0] n_sl, n_sr;
    logic [QW-1:0]         n_sll, n_srr;
    logic signed [XW-1:0]  n_slr;

    logic                       w_accept;
    logic signed [SAMPLE_W-1:0] w_ol, w_or;
    logic signed [2*SAMPLE_W-1:0] w_ll, w_rr, w_lr, w_oll, w_orr, w_olr;

    assign i_sample.ready = (r_state == F_IDLE) && !i_qstat.full;
    assign w_accept       = i_sample.valid && i_sample.ready;

    // Slots not yet written since reset read as zero.
    assign w_ol = r_full ? $signed(r_rd[SAMPLE_W-1:0]) : '0;
    assign w_or = r_full ? $signed(r_rd[2*SAMPLE_W-1:SAMPLE_W]) : '0;

    assign w_ll  = i_sample.left_sample * i_sample.left_sample;
    assign w_rr  = i_sample.right_sample * i_sample.right_sample;
    assign w_lr  = i_sample.left_sample * i_sample.right_sample;
    assign w_oll = w_ol * w_ol;
    assign w_orr = w_or * w_or;
    assign w_olr = w_ol * w_or;

    // Sum update: add the new pair, remove the retiring one.
    assign n_sl  = r_sl + SLW'(r_l) - SLW'(r_ol);
    assign n_sr  = r_sr + SLW'(r_r) - SLW'(r_or);
    assign n_sll = r_sll + QW'(r_pll) - QW'(r_poll);
    assign n_srr = r_srr + QW'(r_prr) - QW'(r_porr);
    assign n_slr = r_slr + XW'(r_plr) - XW'(r_polr);

    assign o_push      = (r_state == F_UPD);
    assign o_push_data = {n_sl, n_sr, n_sll, n_srr, n_slr};

    // Sequencer, ring pointer and sums.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_widx  <= '0;
            r_full  <= 1'b0;
            r_sl    <= '0;
            r_sr    <= '0;
            r_sll   <= '0;
            r_srr   <= '0;
            r_slr   <= '0;
        end else begin
            case (r_state)
                F_IDLE: begin
                    if (w_accept) begin
                        r_l     <= i_sample.left_sample;
                        r_r     <= i_sample.right_sample;
                        r_pll   <= w_ll;
                        r_prr   <= w_rr;
                        r_plr   <= w_lr;
                        r_state <= F_OLD;
                    end
                end
                F_OLD: begin
                    r_ol   <= w_ol;
                    r_or   <= w_or;
                    r_poll <= w_oll;
                    r_porr <= w_orr;
                    r_polr <= w_olr;
                    if (r_widx == AW'(WINDOW - 1)) begin
                        r_widx <= '0;
                        r_full <= 1'b1;
                    end else begin
                        r_widx <= r_widx + 1'b1;
                    end
                    r_state <= F_UPD;
                end
                F_UPD: begin
                    r_sl    <= n_sl;
                    r_sr    <= n_sr;
                    r_sll   <= n_sll;
                    r_srr   <= n_srr;
                    r_slr   <= n_slr;
                    r_state <= F_IDLE;
                end
                default: begin
                    r_state <= F_IDLE;
                end
            endcase
        end
    end

    // Ring access: read the slot at transfer, overwrite it in the cycle after.
    always_ff @(posedge i_clk) begin
        r_rd <= r_mem[r_widx];
        if (r_state == F_OLD) begin
            r_mem[r_widx] <= {r_r, r_l};
        end
    end

endmodule

// ----- design/scm_engine.sv -----
`timescale 1ns / 1ps
`include "stereo_correlation_meter_unit_defines.svh"
// ---------------------------------------------------------------------------
// Correlation meter back end
// Turns a snapshot of running sums into the Pearson correlation with one
// shared multiplier, a square-root unit and a restoring divider.
// ---------------------------------------------------------------------------
module scm_engine #(
    parameter int  WINDOW = 1024,
    localparam int CL     = $clog2(WINDOW),
    localparam int SLW    = 16 + CL,
    localparam int QW     = 31 + CL,
    localparam int XW     = 32 + CL,
    localparam int DW     = 2 * SLW + 2 * QW + XW
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [scm_pkg::FLOOR_W-1:0]     i_cfg_wdata,
    input  scm_pkg::t_q_status              i_qstat,
    input  logic [DW-1:0]                   i_pop_data,
    output logic                            o_pop,
    scm_out_if.source                       o_result
);
    import scm_pkg::*;

    localparam logic [31:0]     N_CONST  = 32'(WINDOW);
    localparam longint          NN1_L    = longint'(WINDOW) * longint'(WINDOW - 1);
    localparam logic [31:0]     NN1      = 32'(NN1_L);
    localparam logic [WIDE_W-1:0] CLIP_MAX = {16'b0, {48{1'b1}}};

    typedef enum logic [3:0] {
        E_IDLE,
        E_MLOAD,
        E_MRUN,
        E_CHECK,
        E_NORM,
        E_SQRT,
        E_DIVSET,
        E_DIV,
        E_SAT,
        E_OUT
    } t_estate;

    typedef enum logic [2:0] {
        OP_NLL,
        OP_LL,
        OP_NRR,
        OP_RR,
        OP_NLR,
        OP_LR,
        OP_THR,
        OP_DEN
    } t_op;

    t_estate r_state;
    t_op     r_op;

    // Snapshot of the sums and the configured floor.
    logic signed [SLW-1:0] r_sl, r_sr;
    logic [QW-1:0]         r_sll, r_srr;
    logic signed [XW-1:0]  r_slr;
    logic [FLOOR_W-1:0]    r_floor;

    // Shared multiplier.
    logic [WIDE_W-1:0] r_ma, r_macc;
    logic [31:0]       r_mb;
    logic              r_mstep;

    // Intermediate terms.
    logic signed [WIDE_W-1:0] r_t, r_c;
    logic [WIDE_W-1:0]        r_a, r_b, r_thr;

    // Square-root unit.
    logic [WIDE_W-1:0] r_v;
    logic [5:0]        r_k, r_ka, r_kb;
    logic [31:0]       r_root, r_bit;
    logic              r_sel;
    logic [ROOT_W-1:0] r_sa, r_sb;

    // Divider.
    logic [31:0]       r_d, r_rem;
    logic [WIDE_W-1:0] r_x;
    logic [16:0]       r_q;
    logic [4:0]        r_cnt;
    logic              r_neg;

    // Result and output register.
    logic signed [CORR_W-1:0] r_rcorr, r_ocorr;
    logic                     r_rflag, r_oflag, r_ovalid;

    logic [SLW-1:0]           w_mag_sl, w_mag_sr;
    logic [XW-1:0]            w_mag_slr;
    logic [WIDE_W-1:0]        w_op_a;
    logic [31:0]              w_op_b;
    logic [WIDE_W+15:0]       w_part;
    logic [WIDE_W-1:0]        w_prod;
    logic signed [WIDE_W-1:0] w_diff;
    logic                     w_lr_neg;
    logic                     w_low;
    logic [32:0]              w_sq_sum;
    logic                     w_sq_ge;
    logic [31:0]              w_root_n;
    logic [WIDE_W-1:0]        w_v_n;
    logic [WIDE_W-1:0]        w_mag_c, w_xc, w_dvd;
    logic [6:0]               w_e;
    logic                     w_ovf;
    logic [32:0]              w_rem2;
    logic                     w_dge;
    logic [31:0]              w_rem_n;
    logic [16:0]              w_qneg;

    assign o_pop = (r_state == E_IDLE) && !i_qstat.empty;

    assign o_result.valid         = r_ovalid;
    assign o_result.correlation   = r_ocorr;
    assign o_result.level_too_low = r_oflag;

    // Magnitudes of the signed sums.
    assign w_mag_sl  = r_sl[SLW-1] ? SLW'(-r_sl) : SLW'(r_sl);
    assign w_mag_sr  = r_sr[SLW-1] ? SLW'(-r_sr) : SLW'(r_sr);
    assign w_mag_slr = r_slr[XW-1] ? XW'(-r_slr) : XW'(r_slr);
    assign w_lr_neg  = r_sl[SLW-1] ^ r_sr[SLW-1];

    // Operand selection for the shared multiplier.
    always_comb begin
        case (r_op)
            OP_NLL:  begin w_op_a = WIDE_W'(r_sll);     w_op_b = N_CONST;       end
            OP_LL:   begin w_op_a = WIDE_W'(w_mag_sl);  w_op_b = 32'(w_mag_sl); end
            OP_NRR:  begin w_op_a = WIDE_W'(r_srr);     w_op_b = N_CONST;       end
            OP_RR:   begin w_op_a = WIDE_W'(w_mag_sr);  w_op_b = 32'(w_mag_sr); end
            OP_NLR:  begin w_op_a = WIDE_W'(w_mag_slr); w_op_b = N_CONST;       end
            OP_LR:   begin w_op_a = WIDE_W'(w_mag_sl);  w_op_b = 32'(w_mag_sr); end
            OP_THR:  begin w_op_a = WIDE_W'(r_floor);   w_op_b = NN1;           end
            OP_DEN:  begin w_op_a = WIDE_W'(r_sa);      w_op_b = 32'(r_sb);     end
            default: begin w_op_a = '0;                 w_op_b = '0;            end
        endcase
    end

    // One 16-bit slice of the multiplier operand per cycle.
    assign w_part = r_ma * r_mb[15:0];
    assign w_prod = r_macc + w_part[WIDE_W-1:0];
    assign w_diff = r_t - $signed(w_prod);

    // Variance test against zero and the floor.
    assign w_low = (r_a == '0) || (r_b == '0) || (r_a < r_thr) || (r_b < r_thr);

    // One result bit of the square root per cycle.
    assign w_sq_sum = {1'b0, r_root} + {1'b0, r_bit};
    assign w_sq_ge  = ({1'b0, r_v[31:0]} >= w_sq_sum);
    assign w_root_n = w_sq_ge ? (r_root >> 1) + r_bit : r_root >> 1;
    assign w_v_n    = w_sq_ge ? r_v - WIDE_W'(w_sq_sum) : r_v;

    // Dividend: |C| scaled by 2^15 over the combined root shift.
    assign w_mag_c = r_c[WIDE_W-1] ? WIDE_W'(-r_c) : WIDE_W'(r_c);
    assign w_e     = 7'(({1'b0, r_ka} + {1'b0, r_kb}) >> 1);
    assign w_xc    = (w_mag_c[WIDE_W-1:48] != '0) ? CLIP_MAX : w_mag_c;
    assign w_dvd   = (w_e >= 7'd15) ? (w_mag_c >> (w_e - 7'd15)) : (w_xc << (7'd15 - w_e));
    assign w_ovf   = (w_dvd[WIDE_W-1:17] >= {15'b0, r_d});

    // One quotient bit per cycle.
    assign w_rem2  = {r_rem, r_x[16]};
    assign w_dge   = (w_rem2 >= {1'b0, r_d});
    assign w_rem_n = w_dge ? 32'(w_rem2 - {1'b0, r_d}) : w_rem2[31:0];
    assign w_qneg  = ~r_q + 17'd1;

    // Sequencer and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= E_IDLE;
            r_op     <= OP_NLL;
            r_ovalid <= 1'b0;
            r_floor  <= FLOOR_RESET;
        end else begin
            if (i_cfg_we) begin
                r_floor <= i_cfg_wdata;
            end
            // The output register empties on a transfer unless a new result replaces it.
            if (r_ovalid && o_result.ready && r_state != E_OUT) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                E_IDLE: begin
                    if (!i_qstat.empty) begin
                        {r_sl, r_sr, r_sll, r_srr, r_slr} <= i_pop_data;
                        r_op    <= OP_NLL;
                        r_state <= E_MLOAD;
                    end
                end
                E_MLOAD: begin
                    r_ma    <= w_op_a;
                    r_mb    <= w_op_b;
                    r_macc  <= '0;
                    r_mstep <= 1'b0;
                    r_state <= E_MRUN;
                end
                E_MRUN: begin
                    if (!r_mstep) begin
                        r_macc  <= w_prod;
                        r_ma    <= r_ma << 16;
                        r_mb    <= r_mb >> 16;
                        r_mstep <= 1'b1;
                    end else begin
                        case (r_op)
                            OP_NLL: begin
                                r_t     <= $signed(w_prod);
                                r_op    <= OP_LL;
                                r_state <= E_MLOAD;
                            end
                            OP_LL: begin
                                r_a     <= w_diff[WIDE_W-1] ? '0 : w_diff;
                                r_op    <= OP_NRR;
                                r_state <= E_MLOAD;
                            end
                            OP_NRR: begin
                                r_t     <= $signed(w_prod);
                                r_op    <= OP_RR;
                                r_state <= E_MLOAD;
                            end
                            OP_RR: begin
                                r_b     <= w_diff[WIDE_W-1] ? '0 : w_diff;
                                r_op    <= OP_NLR;
                                r_state <= E_MLOAD;
                            end
                            OP_NLR: begin
                                r_t     <= r_slr[XW-1] ? -$signed(w_prod) : $signed(w_prod);
                                r_op    <= OP_LR;
                                r_state <= E_MLOAD;
                            end
                            OP_LR: begin
                                r_c     <= w_lr_neg ? r_t + $signed(w_prod) : w_diff;
                                r_op    <= OP_THR;
                                r_state <= E_MLOAD;
                            end
                            OP_THR: begin
                                r_thr   <= w_prod;
                                r_state <= E_CHECK;
                            end
                            OP_DEN: begin
                                r_d     <= (w_prod[31:0] == '0) ? 32'd1 : w_prod[31:0];
                                r_state <= E_DIVSET;
                            end
                            default: begin
                                r_state <= E_IDLE;
                            end
                        endcase
                    end
                end
                E_CHECK: begin
                    if (w_low) begin
                        r_rcorr <= '0;
                        r_rflag <= 1'b1;
                        r_state <= E_OUT;
                    end else begin
                        r_v     <= r_a;
                        r_k     <= '0;
                        r_sel   <= 1'b0;
                        r_state <= E_NORM;
                    end
                end
                E_NORM: begin
                    // Even right shift until the value fits in 32 bits.
                    if (r_v[WIDE_W-1:32] != '0) begin
                        r_v <= r_v >> 2;
                        r_k <= r_k + 6'd2;
                    end else begin
                        r_root  <= '0;
                        r_bit   <= 32'h4000_0000;
                        r_state <= E_SQRT;
                    end
                end
                E_SQRT: begin
                    r_root <= w_root_n;
                    r_bit  <= r_bit >> 2;
                    if (r_bit == 32'd1 && !r_sel) begin
                        // First root done: start on the right channel.
                        r_sa    <= w_root_n[ROOT_W-1:0];
                        r_ka    <= r_k;
                        r_v     <= r_b;
                        r_k     <= '0;
                        r_sel   <= 1'b1;
                        r_state <= E_NORM;
                    end else begin
                        r_v <= w_v_n;
                        if (r_bit == 32'd1) begin
                            r_sb    <= w_root_n[ROOT_W-1:0];
                            r_kb    <= r_k;
                            r_op    <= OP_DEN;
                            r_state <= E_MLOAD;
                        end
                    end
                end
                E_DIVSET: begin
                    r_neg <= r_c[WIDE_W-1];
                    if (w_ovf) begin
                        r_q     <= '1;
                        r_state <= E_SAT;
                    end else begin
                        r_q     <= '0;
                        r_rem   <= w_dvd[48:17];
                        r_x     <= w_dvd;
                        r_cnt   <= 5'd16;
                        r_state <= E_DIV;
                    end
                end
                E_DIV: begin
                    r_rem <= w_rem_n;
                    r_q   <= {r_q[15:0], w_dge};
                    r_x   <= r_x << 1;
                    if (r_cnt == '0) begin
                        r_state <= E_SAT;
                    end else begin
                        r_cnt <= r_cnt - 5'd1;
                    end
                end
                E_SAT: begin
                    r_rflag <= 1'b0;
                    if (r_neg) begin
                        r_rcorr <= (r_q > 17'd32768) ? CORR_MIN : $signed(w_qneg[CORR_W-1:0]);
                    end else begin
                        r_rcorr <= (r_q > 17'd32767) ? CORR_MAX : $signed(r_q[CORR_W-1:0]);
                    end
                    r_state <= E_OUT;
                end
                E_OUT: begin
                    if (!r_ovalid || o_result.ready) begin
                        r_ovalid <= 1'b1;
                        r_ocorr  <= r_rcorr;
                        r_oflag  <= r_rflag;
                        r_state  <= E_IDLE;
                    end
                end
                default: begin
                    r_state <= E_IDLE;
                end
            endcase
        end
    end

    `SCM_ASSERT(a_flag_zero, i_clk, i_rst_n, r_ovalid && r_oflag |-> r_ocorr == '0, "flagged result is not zero")
    `SCM_ASSERT(a_rem_below_div, i_clk, i_rst_n, r_state == E_DIV |-> r_rem < r_d, "divider remainder not below divisor")
    `SCM_ASSERT(a_roots_nonzero, i_clk, i_rst_n, r_state == E_DIVSET |-> r_sa != '0 && r_sb != '0 && r_d != '0, "zero root reached the divider")

endmodule

// ----- design/stereo_correlation_meter_unit.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Stereo correlation meter
// Pearson correlation of left and right over a sliding window of sample
// pairs, with a variance floor below which the result is forced to zero.
// ---------------------------------------------------------------------------
//  channel     | dir | handshake     | payload
//  ------------+-----+---------------+-----------------------------------
//  i_sample    | in  | valid / ready | left_sample, right_sample (Q1.15)
//  o_result    | out | valid / ready | correlation (Q1.15), level_too_low
//  i_cfg_*     | in  | write enable  | variance floor, 31 bits
//
// The front end takes a new pair only after its retire and update states,
// while the snapshot queue has room. The back end's time per result is set
// by the shared 64x16 multiplier (8 products), the bit-serial square root
// (two roots) and the 17-step divider; a result under the floor skips the
// roots and the divider. Reset is synchronous; the window reads as zero
// until each slot is written, so no clearing pass is needed. A stalled output
// holds one result while the queue keeps up to two more snapshots in flight.
// ---------------------------------------------------------------------------
module stereo_correlation_meter_unit #(
    parameter int WINDOW = 1024
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    scm_in_if.sink                      i_sample,
    scm_out_if.source                   o_result,
    input  logic                        i_cfg_we,
    input  logic [scm_pkg::FLOOR_W-1:0] i_cfg_wdata
);
    import scm_pkg::*;

    localparam int CL  = $clog2(WINDOW);
    localparam int SLW = 16 + CL;
    localparam int QW  = 31 + CL;
    localparam int XW  = 32 + CL;
    localparam int DW  = 2 * SLW + 2 * QW + XW;

    logic          w_push;
    logic          w_pop;
    logic [DW-1:0] w_push_data;
    logic [DW-1:0] w_pop_data;
    t_q_status     w_qstat;

    // Front end: window ring and running sums.
    scm_front #(
        .WINDOW (WINDOW)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_sample    (i_sample),
        .i_qstat     (w_qstat),
        .o_push      (w_push),
        .o_push_data (w_push_data)
    );

    // Snapshot queue between the two halves.
    scm_queue #(
        .DW (DW)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_push_data (w_push_data),
        .i_pop       (w_pop),
        .o_pop_data  (w_pop_data),
        .o_qstat     (w_qstat)
    );

    // Back end: correlation arithmetic and output register.
    scm_engine #(
        .WINDOW (WINDOW)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_qstat     (w_qstat),
        .i_pop_data  (w_pop_data),
        .o_pop       (w_pop),
        .o_result    (o_result)
    );

endmodule
